[hw/rtl/tsat_pkg.sv]
`default_nettype none

package tsat_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int EIDX_W   = 4;
    localparam int CMP_W    = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } tsat_cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOIDX = 2'd2
    } tsat_status_t;

    typedef struct packed {
        tsat_cmd_t         cmd;
        logic [4:0]        event_hour;
        logic [5:0]        event_minute;
        logic [3:0]        device_code;
        logic [7:0]        device_setting;
        logic [EIDX_W-1:0] entry_index;
    } tsat_req_t;

    typedef struct packed {
        tsat_status_t status;
        logic [4:0]   entry_count;
        logic [4:0]   read_hour;
        logic [5:0]   read_minute;
        logic [3:0]   read_device;
        logic [7:0]   read_setting;
    } tsat_rsp_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [3:0] device;
        logic [7:0] setting;
    } tsat_entry_t;

    // per-cell control from the table front end
    typedef struct packed {
        logic ins_en;     // insert taking place this cycle
        logic del_en;     // delete taking place this cycle
        logic occupied;   // cell position below count
        logic at_end;     // cell position equals count
        logic del_shift;  // cell position at or above delete index
    } tsat_cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/time_sorted_action_table_top.sv]
`default_nettype none
// Time-sorted action table.
// req channel (req_valid/req_ready/req): one beat is one command: insert an
// action (hour, minute, device, setting), delete the entry at entry_index, or
// read the entry at entry_index. Entries stay in ascending (hour, minute)
// order; an insert lands behind entries of equal time.
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one beat per command with
// status, the count after the command, and the entry fields on a good read.
// Storage is a row of CAPACITY cells; on every command each cell compares
// its entry with the incoming time; on an insert or delete it loads the new
// entry or its left or right neighbor, so the whole shift happens at once.
// Latency: the response is registered, valid the cycle after the command beat.
// Throughput: one command per cycle while no response is held back by a low
// rsp_ready, set by the whole-row cell update and the one-deep response register.
// Stall: while a response waits and rsp_ready is low, req_ready is low; the
// table does not change until the response is taken.
// Reset: clears the count and the response valid; cell contents are
// undefined but never read before being written.
module time_sorted_action_table_top
    import tsat_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire tsat_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output tsat_rsp_t      rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    tsat_rsp_t        rsp_reg;
    tsat_rsp_t        rsp_next;

    logic             accept;
    logic             full;
    logic             idx_present;
    logic [IDX_W-1:0] rd_sel;
    logic             ins_ok;
    logic             del_ok;
    tsat_entry_t      new_entry;

    tsat_entry_t      cell_entry [CAPACITY];
    logic             cell_gt    [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign idx_present = (CMP_W'(req.entry_index) < CMP_W'(count_reg));
    assign rd_sel      = IDX_W'(req.entry_index);

    assign ins_ok = accept && (req.cmd == CMD_INSERT) && !full;
    assign del_ok = accept && (req.cmd == CMD_DELETE) && idx_present;

    assign new_entry.hour    = req.event_hour;
    assign new_entry.minute  = req.event_minute;
    assign new_entry.device  = req.device_code;
    assign new_entry.setting = req.device_setting;

    // row of cells; cell 0 has no left neighbor, the last no right neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        tsat_cell_ctrl_t ctrl;
        tsat_entry_t     left_entry;
        logic            left_gt;
        tsat_entry_t     right_entry;

        assign ctrl.ins_en    = ins_ok;
        assign ctrl.del_en    = del_ok;
        assign ctrl.occupied  = (CNT_W'(i) < count_reg);
        assign ctrl.at_end    = (CNT_W'(i) == count_reg);
        assign ctrl.del_shift = (CMP_W'(i) >= CMP_W'(req.entry_index));

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        tsat_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        if (ins_ok)
            count_next = count_reg + CNT_W'(1);
        else if (del_ok)
            count_next = count_reg - CNT_W'(1);

        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next             = '0;
            rsp_next.status      = ST_OK;
            unique case (req.cmd)
                CMD_INSERT:
                begin
                    if (full)
                        rsp_next.status = ST_FULL;
                end
                CMD_DELETE:
                begin
                    if (!idx_present)
                        rsp_next.status = ST_NOIDX;
                end
                CMD_READ:
                begin
                    if (!idx_present)
                    begin
                        rsp_next.status = ST_NOIDX;
                    end
                    else
                    begin
                        rsp_next.read_hour    = cell_entry[rd_sel].hour;
                        rsp_next.read_minute  = cell_entry[rd_sel].minute;
                        rsp_next.read_device  = cell_entry[rd_sel].device;
                        rsp_next.read_setting = cell_entry[rd_sel].setting;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
            rsp_next.entry_count = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[hw/rtl/tsat_cell.sv]
`default_nettype none

module tsat_cell
    import tsat_pkg::*;
(
    input  wire logic            clk,
    input  wire tsat_cell_ctrl_t ctrl,
    input  wire tsat_entry_t     new_entry,
    input  wire tsat_entry_t     left_entry,
    input  wire logic            left_gt,
    input  wire tsat_entry_t     right_entry,
    output tsat_entry_t          entry,
    output logic                 gt
);

    tsat_entry_t entry_reg;
    tsat_entry_t entry_next;

    // later in time than the incoming item; equal times stay ahead of it
    assign gt = ctrl.occupied &&
                ({entry_reg.hour, entry_reg.minute} > {new_entry.hour, new_entry.minute});

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (left_gt)
                entry_next = left_entry;
            else if (gt || ctrl.at_end)
                entry_next = new_entry;
        end
        else if (ctrl.del_en && ctrl.del_shift)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[tb/time_sorted_action_table_top_tb.sv]
module time_sorted_action_table_top_tb
    import tsat_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int RAND_BEATS_PER_PHASE = 476;   // four phases, 1904 beats in all
    localparam int CYCLE_LIMIT          = 300000; // slowest legal run is far below
    localparam int DRAIN_CYCLES         = 4;      // response is registered, one entry deep

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    tsat_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    tsat_rsp_t rsp;

    // Hand-typed response that rides along with the request beat. When set,
    // it replaces the predicted response as the expectation for that beat.
    logic      req_typed = 1'b0;
    tsat_rsp_t req_want  = '0;

    int        idle_pct  = 0;  // sender: chance per cycle of holding valid low
    int        stall_pct = 0;  // receiver: chance per cycle of holding ready low
    int        errors    = 0;
    int        cycles    = 0;

    // Shadow copy of the table and its occupancy, kept in accept order.
    tsat_entry_t shadow_tbl [CAPACITY];
    int          shadow_count = 0;

    // Responses still owed by the block, oldest first.
    tsat_rsp_t   pending_rsp [$];

    typedef struct {
        tsat_req_t beat;
        int        reps;
        bit        typed;
        tsat_rsp_t want;
    } dir_row_t;

    dir_row_t dir_tab [$];

    time_sorted_action_table_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cycle watchdog; also covers the wait for outstanding responses.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL time_sorted_action_table_top");
            $finish;
        end
    end

    // Receiver back-pressure, re-rolled every cycle.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) < stall_pct)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= 1'b1;
    end

    // Apply one accepted command to the shadow table and return the response
    // the block owes for it. Inserts land behind every entry of equal time;
    // the ordering key is the raw {hour, minute} bits, so out-of-range hours
    // sort above all legal times.
    function automatic tsat_rsp_t table_apply(tsat_req_t r);
        tsat_rsp_t   o;
        tsat_entry_t e;
        int          pos;
        int          idx;
        o        = '0;
        o.status = ST_OK;
        idx      = int'(r.entry_index);
        case (r.cmd)
            CMD_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    e.hour    = r.event_hour;
                    e.minute  = r.event_minute;
                    e.device  = r.device_code;
                    e.setting = r.device_setting;
                    pos = shadow_count;
                    while (pos > 0 && {shadow_tbl[pos-1].hour, shadow_tbl[pos-1].minute}
                                      > {e.hour, e.minute})
                        pos--;
                    for (int k = shadow_count; k > pos; k--)
                        shadow_tbl[k] = shadow_tbl[k-1];
                    shadow_tbl[pos] = e;
                    shadow_count++;
                end
            end
            CMD_DELETE:
            begin
                if (idx >= shadow_count)
                    o.status = ST_NOIDX;
                else
                begin
                    for (int k = idx; k + 1 < shadow_count; k++)
                        shadow_tbl[k] = shadow_tbl[k+1];
                    shadow_count--;
                end
            end
            CMD_READ:
            begin
                if (idx >= shadow_count)
                    o.status = ST_NOIDX;
                else
                begin
                    o.read_hour    = shadow_tbl[idx].hour;
                    o.read_minute  = shadow_tbl[idx].minute;
                    o.read_device  = shadow_tbl[idx].device;
                    o.read_setting = shadow_tbl[idx].setting;
                end
            end
            default: ;  // unused command: no change, plain OK
        endcase
        o.entry_count = 5'(shadow_count);
        return o;
    endfunction

    task automatic report(string name, int want, int got);
        errors++;
        $display("%0t ERROR %s expected %0d actual %0d", $time, name, want, got);
    endtask

    // Scoreboard. Both handshakes are sampled at the edge where they complete.
    // The response check runs before the new expectation is queued: with the
    // response registered, a response never belongs to the beat accepted at the
    // same edge.
    always @(posedge clk)
    begin
        tsat_rsp_t want;
        tsat_rsp_t pred;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t ERROR response beat with none pending: status %0d count %0d",
                         $time, rsp.status, rsp.entry_count);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report("status", want.status, rsp.status);
                if (rsp.entry_count !== want.entry_count)
                    report("entry_count", want.entry_count, rsp.entry_count);
                if (rsp.read_hour !== want.read_hour)
                    report("read_hour", want.read_hour, rsp.read_hour);
                if (rsp.read_minute !== want.read_minute)
                    report("read_minute", want.read_minute, rsp.read_minute);
                if (rsp.read_device !== want.read_device)
                    report("read_device", want.read_device, rsp.read_device);
                if (rsp.read_setting !== want.read_setting)
                    report("read_setting", want.read_setting, rsp.read_setting);
            end
        end
        if (rst_n && req_valid && req_ready)
        begin
            pred = table_apply(req);
            pending_rsp.push_back(req_typed ? req_want : pred);
        end
    end

    // One request beat. Valid drops only during sender idle cycles, never
    // while a beat is waiting for ready.
    task automatic send_beat(tsat_req_t r, bit typed, tsat_rsp_t want);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        req_typed <= typed;
        req_want  <= want;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Directed table entry; the response fields are only used when typed.
    task automatic row(tsat_cmd_t c, int h, int m, int d, int s, int idx, int reps,
                       bit typed, tsat_status_t st = ST_OK, int cnt = 0,
                       int rh = 0, int rm = 0, int rd = 0, int rs = 0);
        dir_row_t t;
        t.beat.cmd            = c;
        t.beat.event_hour     = 5'(h);
        t.beat.event_minute   = 6'(m);
        t.beat.device_code    = 4'(d);
        t.beat.device_setting = 8'(s);
        t.beat.entry_index    = EIDX_W'(idx);
        t.reps                = reps;
        t.typed               = typed;
        t.want                = '0;
        t.want.status         = st;
        t.want.entry_count    = 5'(cnt);
        t.want.read_hour      = 5'(rh);
        t.want.read_minute    = 6'(rm);
        t.want.read_device    = 4'(rd);
        t.want.read_setting   = 8'(rs);
        dir_tab.push_back(t);
    endtask

    // Random command. Filling favors inserts, draining favors deletes, so the
    // count sweeps between empty and full. A share of times is drawn from a
    // tiny window to pile up equal keys and exercise arrival-order ties;
    // another share uses raw out-of-range hours and minutes.
    function automatic tsat_req_t rand_beat(bit filling);
        tsat_req_t r;
        int        pick;
        int        tmode;
        int        hi;
        pick = $urandom_range(0, 99);
        if (filling)
            r.cmd = (pick < 50) ? CMD_INSERT : (pick < 65) ? CMD_DELETE :
                    (pick < 95) ? CMD_READ : CMD_NOP;
        else
            r.cmd = (pick < 15) ? CMD_INSERT : (pick < 55) ? CMD_DELETE :
                    (pick < 95) ? CMD_READ : CMD_NOP;
        tmode = $urandom_range(0, 9);
        if (tmode == 0)
        begin
            r.event_hour   = 5'($urandom_range(0, 31));
            r.event_minute = 6'($urandom_range(0, 63));
        end
        else if (tmode <= 3)
        begin
            r.event_hour   = 5'($urandom_range(0, 1));
            r.event_minute = 6'($urandom_range(0, 2));
        end
        else
        begin
            r.event_hour   = 5'($urandom_range(0, 23));
            r.event_minute = 6'($urandom_range(0, 59));
        end
        r.device_code    = 4'($urandom_range(0, 15));
        r.device_setting = 8'($urandom_range(0, 255));
        // mostly a present index or one past the end; now and then anything
        hi = (shadow_count > 15) ? 15 : shadow_count;
        if ($urandom_range(0, 9) == 0)
            r.entry_index = EIDX_W'($urandom_range(0, 15));
        else
            r.entry_index = EIDX_W'($urandom_range(0, hi));
        return r;
    endfunction

    initial
    begin
        tsat_rsp_t no_rsp;
        bit        filling;
        no_rsp  = '0;
        filling = 1'b1;

        // Directed: empty-table errors, the unused command, extreme and
        // out-of-range times, equal-time ordering, filling to the refusal,
        // and draining back to empty.
        row(CMD_READ,   0,  0,  0,   0,  0,  1, 1'b1, ST_NOIDX, 0);
        row(CMD_DELETE, 0,  0,  0,   0,  0,  1, 1'b1, ST_NOIDX, 0);
        row(CMD_NOP,   31, 63, 15, 255, 15,  1, 1'b1, ST_OK,    0);
        row(CMD_INSERT,23, 59, 15, 255,  0,  1, 1'b1, ST_OK,    1);
        row(CMD_INSERT, 0,  0,  0,   0,  0,  1, 1'b1, ST_OK,    2);
        row(CMD_INSERT,31, 63, 10, 165,  0,  1, 1'b1, ST_OK,    3);
        row(CMD_INSERT,12, 30,  1,  10,  0,  1, 1'b1, ST_OK,    4);
        row(CMD_INSERT,12, 30,  2,  20,  0,  1, 1'b1, ST_OK,    5);
        row(CMD_READ,   0,  0,  0,   0,  0,  1, 1'b1, ST_OK,    5);
        row(CMD_READ,   0,  0,  0,   0,  1,  1, 1'b0);
        row(CMD_READ,   0,  0,  0,   0,  2,  1, 1'b0);
        row(CMD_READ,   0,  0,  0,   0,  4,  1, 1'b1, ST_OK, 5, 31, 63, 10, 165);
        row(CMD_READ,   0,  0,  0,   0,  5,  1, 1'b1, ST_NOIDX, 5);
        row(CMD_DELETE, 0,  0,  0,   0, 15,  1, 1'b1, ST_NOIDX, 5);
        row(CMD_DELETE, 0,  0,  0,   0,  1,  1, 1'b0);
        row(CMD_READ,   0,  0,  0,   0,  1,  1, 1'b0);
        row(CMD_INSERT, 7,  7,  3, 128,  0, 12, 1'b0);
        row(CMD_INSERT, 1,  1,  1,   1,  0,  1, 1'b1, ST_FULL, 16);
        row(CMD_READ,   0,  0,  0,   0, 15,  1, 1'b0);
        row(CMD_DELETE, 0,  0,  0,   0, 15,  1, 1'b0);
        row(CMD_DELETE, 0,  0,  0,   0,  0, 15, 1'b0);
        row(CMD_READ,   0,  0,  0,   0,  0,  1, 1'b1, ST_NOIDX, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            for (int k = 0; k < dir_tab[i].reps; k++)
                send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases: free-running, sender gaps, receiver stalls, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 72; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int i = 0; i < RAND_BEATS_PER_PHASE; i++)
            begin
                // flip direction at the ends, with an occasional early turn
                if (shadow_count >= CAPACITY)
                    filling = 1'b0;
                else if (shadow_count == 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 49) == 0)
                    filling = !filling;
                send_beat(rand_beat(filling), 1'b0, no_rsp);
            end
        end
        req_valid <= 1'b0;

        // Let the last responses come out, then watch for strays.
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_rsp.size() != 0)
        begin
            errors++;
            $display("%0t ERROR %0d responses never arrived", $time, pending_rsp.size());
        end
        if (errors == 0)
            $display("PASS time_sorted_action_table_top");
        else
            $display("FAIL time_sorted_action_table_top");
        $finish;
    end

endmodule
